>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lpht_pkg.sv
package lpht_pkg;

    localparam int DEFAULT_TABLE_SLOTS = 1024;
    localparam int DEFAULT_MAX_MATCHES = 64;

    localparam int KEY_W   = 32;
    localparam int ROW_W   = 32;
    localparam int CAP_W   = 4;
    localparam int CAP_MIN = 4;

    localparam logic [CAP_W-1:0] CAP_RESET  = 4'd10;
    localparam logic [KEY_W-1:0] CRC_POLY   = 32'h82F6_3B78;
    localparam logic [KEY_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0] EMPTY_MARK = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_PROBE  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                     opcode;
        logic signed [KEY_W-1:0] key;
        logic [ROW_W-1:0]        row_number;
    } item_t;

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] build_row;
        logic [ROW_W-1:0] probe_row;
        status_t          status;
        logic             last;
    } result_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_HASH,
        S_READ,
        S_EVAL,
        S_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        EMIT_NONE,
        EMIT_CLEAR,
        EMIT_NOP,
        EMIT_IGNORED,
        EMIT_INSERTED,
        EMIT_FULL,
        EMIT_MISS,
        EMIT_PEND_MORE,
        EMIT_PEND_LAST,
        EMIT_PEND_OVF
    } emit_t;

    typedef struct packed {
        logic  accept;
        logic  sweep;
        logic  hash_step;
        logic  advance;
        logic  write;
        logic  capture;
        emit_t emit;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic marker_key;
        logic hash_done;
        logic sweep_done;
        logic used;
        logic key_match;
        logic last_step;
        logic has_pending;
        logic match_full;
    } dp_status_t;

    // Eight bit-steps of the reflected CRC32C shift register.
    function automatic logic [KEY_W-1:0] crc_byte_steps(input logic [KEY_W-1:0] crc_in);
        logic [KEY_W-1:0] c;
        c = crc_in;
        for (int b = 0; b < 8; b++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {KEY_W{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> rtl/core/lpht_ctrl.sv
`include "assert_macros.svh"

module lpht_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lpht_pkg::dp_status_t  stat,
    output lpht_pkg::dp_cmd_t     cmd
);

    lpht_pkg::state_t state_reg;
    lpht_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::S_INIT:
            begin
                if (stat.sweep_done)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = lpht_pkg::S_DECODE;
                end
            end
            lpht_pkg::S_DECODE:
            begin
                case (stat.op)
                    lpht_pkg::OP_CLEAR:  state_next = lpht_pkg::S_CLEAR;
                    lpht_pkg::OP_INSERT: state_next = stat.marker_key ? lpht_pkg::S_IDLE
                                                                      : lpht_pkg::S_HASH;
                    lpht_pkg::OP_PROBE:  state_next = lpht_pkg::S_HASH;
                    default:             state_next = lpht_pkg::S_IDLE;
                endcase
            end
            lpht_pkg::S_CLEAR:
            begin
                if (stat.sweep_done)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_HASH:
            begin
                if (stat.hash_done)
                begin
                    state_next = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_READ:
            begin
                state_next = lpht_pkg::S_EVAL;
            end
            lpht_pkg::S_EVAL:
            begin
                if (!stat.used)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
                else if (stat.op == lpht_pkg::OP_INSERT)
                begin
                    state_next = stat.last_step ? lpht_pkg::S_IDLE : lpht_pkg::S_READ;
                end
                else if (stat.key_match && stat.match_full)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
                else if (stat.key_match)
                begin
                    state_next = stat.last_step ? lpht_pkg::S_FLUSH : lpht_pkg::S_READ;
                end
                else
                begin
                    state_next = stat.last_step ? lpht_pkg::S_IDLE : lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_FLUSH:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.emit = lpht_pkg::EMIT_NONE;
        busy     = (state_reg != lpht_pkg::S_IDLE);
        case (state_reg)
            lpht_pkg::S_INIT:
            begin
                cmd.sweep = 1'b1;
            end
            lpht_pkg::S_IDLE:
            begin
                cmd.accept = start;
            end
            lpht_pkg::S_DECODE:
            begin
                if (stat.op == lpht_pkg::OP_NOP)
                begin
                    cmd.emit = lpht_pkg::EMIT_NOP;
                end
                else if (stat.op == lpht_pkg::OP_INSERT && stat.marker_key)
                begin
                    cmd.emit = lpht_pkg::EMIT_IGNORED;
                end
            end
            lpht_pkg::S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    cmd.emit = lpht_pkg::EMIT_CLEAR;
                end
            end
            lpht_pkg::S_HASH:
            begin
                cmd.hash_step = 1'b1;
            end
            lpht_pkg::S_EVAL:
            begin
                if (stat.op == lpht_pkg::OP_INSERT)
                begin
                    if (!stat.used)
                    begin
                        cmd.write = 1'b1;
                        cmd.emit  = lpht_pkg::EMIT_INSERTED;
                    end
                    else if (stat.last_step)
                    begin
                        cmd.emit = lpht_pkg::EMIT_FULL;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else if (!stat.used || (!stat.key_match && stat.last_step))
                begin
                    cmd.emit = stat.has_pending ? lpht_pkg::EMIT_PEND_LAST
                                                : lpht_pkg::EMIT_MISS;
                end
                else if (stat.key_match && stat.match_full)
                begin
                    cmd.emit = lpht_pkg::EMIT_PEND_OVF;
                end
                else
                begin
                    cmd.advance = !stat.last_step;
                    if (stat.key_match)
                    begin
                        cmd.capture = 1'b1;
                        if (stat.has_pending)
                        begin
                            cmd.emit = lpht_pkg::EMIT_PEND_MORE;
                        end
                    end
                end
            end
            lpht_pkg::S_FLUSH:
            begin
                cmd.emit = lpht_pkg::EMIT_PEND_LAST;
            end
            default:
            begin
                cmd.emit = lpht_pkg::EMIT_NONE;
            end
        endcase
    end

    // A held match may only be sent when one has actually been captured.
    `ASSERT_IMPLY(a_pend_emit_has_entry, clk, rst_n, cmd.emit == lpht_pkg::EMIT_PEND_MORE || cmd.emit == lpht_pkg::EMIT_PEND_LAST || cmd.emit == lpht_pkg::EMIT_PEND_OVF, stat.has_pending)
    // An insert never overwrites an occupied slot.
    `ASSERT_IMPLY(a_write_free_slot, clk, rst_n, cmd.write, !stat.used && stat.op == lpht_pkg::OP_INSERT)
    // After a clear sweep completes the table is ready for a new item.
    `ASSERT_NEXT(a_clear_done_idle, clk, rst_n, state_reg == lpht_pkg::S_CLEAR && stat.sweep_done, !busy)

endmodule

>>> rtl/core/lpht_dp.sv
`include "assert_macros.svh"

module lpht_dp #(
    parameter int TABLE_SLOTS = lpht_pkg::DEFAULT_TABLE_SLOTS,
    parameter int MAX_MATCHES = lpht_pkg::DEFAULT_MAX_MATCHES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lpht_pkg::item_t                 item,
    input  logic                            cfg_we,
    input  logic [lpht_pkg::CAP_W-1:0]      cfg_data,
    input  lpht_pkg::dp_cmd_t               cmd,
    output lpht_pkg::dp_status_t            stat,
    output logic                            result_strobe,
    output lpht_pkg::result_t               result
);

    localparam int ADDR_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(MAX_MATCHES + 1);
    localparam logic [4:0] ADDR_LG = 5'(ADDR_W);

    logic [lpht_pkg::CAP_W-1:0]  cap_reg;
    lpht_pkg::op_t               op_reg;
    logic [lpht_pkg::KEY_W-1:0]  key_reg;
    logic [lpht_pkg::ROW_W-1:0]  row_reg;
    logic [lpht_pkg::KEY_W-1:0]  crc_reg;
    logic [lpht_pkg::KEY_W-1:0]  crc_next;
    logic [1:0]                  byte_reg;
    logic [ADDR_W-1:0]           idx_reg;
    logic [ADDR_W-1:0]           idx_next;
    logic [ADDR_W-1:0]           step_reg;
    logic [ADDR_W-1:0]           sweep_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [lpht_pkg::ROW_W-1:0]  pend_row_reg;
    logic                        used_q_reg;
    logic [lpht_pkg::KEY_W-1:0]  key_q_reg;
    logic [lpht_pkg::ROW_W-1:0]  row_q_reg;
    logic                        strobe_reg;
    lpht_pkg::result_t           result_reg;
    lpht_pkg::result_t           result_next;

    logic [4:0]                  cap_lg;
    logic [ADDR_W-1:0]           mask_w;

    logic                        used_mem [TABLE_SLOTS];
    logic [lpht_pkg::KEY_W-1:0]  key_mem  [TABLE_SLOTS];
    logic [lpht_pkg::ROW_W-1:0]  row_mem  [TABLE_SLOTS];

    always_comb
    begin
        cap_lg = {1'b0, cap_reg};
        if (cap_lg < 5'(lpht_pkg::CAP_MIN))
        begin
            cap_lg = 5'(lpht_pkg::CAP_MIN);
        end
        if (cap_lg > ADDR_LG)
        begin
            cap_lg = ADDR_LG;
        end
    end

    assign mask_w   = {ADDR_W{1'b1}} >> (ADDR_LG - cap_lg);
    assign crc_next = lpht_pkg::crc_byte_steps(crc_reg);
    assign idx_next = (idx_reg + ADDR_W'(1)) & mask_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lpht_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= item.opcode;
            key_reg <= $unsigned(item.key);
            row_reg <= item.row_number;
            crc_reg <= lpht_pkg::CRC_INIT ^ $unsigned(item.key);
        end
        else if (cmd.hash_step)
        begin
            crc_reg <= crc_next;
        end
        if (cmd.capture)
        begin
            pend_row_reg <= row_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            sweep_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                byte_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.hash_step)
                begin
                    byte_reg <= byte_reg + 2'd1;
                end
                if (cmd.capture)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.hash_step && stat.hash_done)
            begin
                idx_reg  <= crc_next[ADDR_W-1:0] & mask_w;
                step_reg <= '0;
            end
            else if (cmd.advance)
            begin
                idx_reg  <= idx_next;
                step_reg <= step_reg + ADDR_W'(1);
            end
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            used_mem[sweep_reg] <= 1'b0;
        end
        else if (cmd.write)
        begin
            used_mem[idx_reg] <= 1'b1;
        end
        if (cmd.write)
        begin
            key_mem[idx_reg] <= key_reg;
            row_mem[idx_reg] <= row_reg;
        end
        used_q_reg <= used_mem[idx_reg];
        key_q_reg  <= key_mem[idx_reg];
        row_q_reg  <= row_mem[idx_reg];
    end

    always_comb
    begin
        result_next = '0;
        case (cmd.emit)
            lpht_pkg::EMIT_CLEAR:
            begin
                result_next.last = 1'b1;
            end
            lpht_pkg::EMIT_NOP:
            begin
                result_next.status = lpht_pkg::ST_IGNORED;
                result_next.last   = 1'b1;
            end
            lpht_pkg::EMIT_IGNORED:
            begin
                result_next.build_row = row_reg;
                result_next.status    = lpht_pkg::ST_IGNORED;
                result_next.last      = 1'b1;
            end
            lpht_pkg::EMIT_INSERTED:
            begin
                result_next.build_row = row_reg;
                result_next.last      = 1'b1;
            end
            lpht_pkg::EMIT_FULL:
            begin
                result_next.build_row = row_reg;
                result_next.status    = lpht_pkg::ST_FULL;
                result_next.last      = 1'b1;
            end
            lpht_pkg::EMIT_MISS:
            begin
                result_next.probe_row = row_reg;
                result_next.last      = 1'b1;
            end
            lpht_pkg::EMIT_PEND_MORE:
            begin
                result_next.hit       = 1'b1;
                result_next.build_row = pend_row_reg;
                result_next.probe_row = row_reg;
            end
            lpht_pkg::EMIT_PEND_LAST:
            begin
                result_next.hit       = 1'b1;
                result_next.build_row = pend_row_reg;
                result_next.probe_row = row_reg;
                result_next.last      = 1'b1;
            end
            lpht_pkg::EMIT_PEND_OVF:
            begin
                result_next.hit       = 1'b1;
                result_next.build_row = pend_row_reg;
                result_next.probe_row = row_reg;
                result_next.status    = lpht_pkg::ST_OVERFLOW;
                result_next.last      = 1'b1;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.emit != lpht_pkg::EMIT_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != lpht_pkg::EMIT_NONE)
        begin
            result_reg <= result_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    always_comb
    begin
        stat             = '0;
        stat.op          = op_reg;
        stat.marker_key  = (key_reg == lpht_pkg::EMPTY_MARK);
        stat.hash_done   = (byte_reg == 2'd3);
        stat.sweep_done  = (sweep_reg == {ADDR_W{1'b1}});
        stat.used        = used_q_reg;
        stat.key_match   = (key_q_reg == key_reg);
        stat.last_step   = (step_reg == mask_w);
        stat.has_pending = (count_reg != '0);
        stat.match_full  = (count_reg == CNT_W'(MAX_MATCHES));
    end

    `ASSERT_IMPLY(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_MATCHES))
    `ASSERT_IMPLY(a_write_not_sweep, clk, rst_n, cmd.write, !cmd.sweep)
    `ASSERT_NEXT(a_emit_strobes, clk, rst_n, cmd.emit != lpht_pkg::EMIT_NONE, result_strobe)

endmodule

>>> rtl/core/linear_probe_hash_join_table.sv
// Flow: a no-op or an ignored insert is decoded after accept and its result registered;
// an insert or probe hashes the key a byte per S_HASH step, then reads each slot into a
// register in S_READ and tests it in S_EVAL; a probe whose walk ends on a match then
// passes S_FLUSH. No new item is taken while busy; a clear sweeps every slot, one per cycle.
// Reset: asynchronous, active low; a sweep of every slot then empties the table with busy
// high. Each result beat is strobed for one cycle and the receiver cannot stall.
module linear_probe_hash_join_table #(
    parameter int TABLE_SLOTS = lpht_pkg::DEFAULT_TABLE_SLOTS,
    parameter int MAX_MATCHES = lpht_pkg::DEFAULT_MAX_MATCHES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lpht_pkg::item_t             item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lpht_pkg::CAP_W-1:0]  cfg_data,
    output logic                        result_strobe,
    output lpht_pkg::result_t           result
);

    lpht_pkg::dp_cmd_t    cmd;
    lpht_pkg::dp_status_t stat;

    assign cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    lpht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

>>> bench/join_table_scoreboard.sv
module join_table_scoreboard #(
    parameter int TABLE_SLOTS = lpht_pkg::DEFAULT_TABLE_SLOTS,
    parameter int MAX_MATCHES = lpht_pkg::DEFAULT_MAX_MATCHES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  lpht_pkg::item_t            item,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [lpht_pkg::CAP_W-1:0] cfg_data,
    input  logic                       result_strobe,
    input  lpht_pkg::result_t          result,
    output int                         mismatches,
    output int                         pending
);

    logic [lpht_pkg::KEY_W-1:0] stored_key [TABLE_SLOTS];
    logic [lpht_pkg::ROW_W-1:0] stored_row [TABLE_SLOTS];
    logic                       slot_taken [TABLE_SLOTS];
    logic [lpht_pkg::CAP_W-1:0] capacity;
    lpht_pkg::result_t          expected_results[$];

    function automatic logic [lpht_pkg::KEY_W-1:0] crc32c_hash(
        input logic [lpht_pkg::KEY_W-1:0] k);
        logic [lpht_pkg::KEY_W-1:0] c;
        int b;
        c = lpht_pkg::CRC_INIT ^ k;
        for (b = 0; b < lpht_pkg::KEY_W; b++)
        begin
            c = (c >> 1) ^ (c[0] ? lpht_pkg::CRC_POLY : '0);
        end
        return c;
    endfunction

    function automatic int unsigned active_slots(input logic [lpht_pkg::CAP_W-1:0] lg);
        int unsigned n;
        n = 1 << ((lg < lpht_pkg::CAP_MIN) ? lpht_pkg::CAP_MIN : lg);
        while (n > TABLE_SLOTS)
        begin
            n = n >> 1;
        end
        return n;
    endfunction

    task automatic push_result(input logic hit, input logic [lpht_pkg::ROW_W-1:0] brow,
                               input logic [lpht_pkg::ROW_W-1:0] prow,
                               input lpht_pkg::status_t st, input logic last);
        lpht_pkg::result_t r;
        r.hit       = hit;
        r.build_row = brow;
        r.probe_row = prow;
        r.status    = st;
        r.last      = last;
        expected_results = {expected_results, r};
    endtask

    task automatic predict_results(input lpht_pkg::item_t it);
        int unsigned       n;
        int unsigned       idx;
        int unsigned       step;
        int                hit_total;
        bit                placed;
        bit                overflowed;
        lpht_pkg::result_t r;
        n = active_slots(capacity);
        idx = crc32c_hash(it.key) & (n - 1);
        hit_total = 0;
        placed = 1'b0;
        overflowed = 1'b0;
        case (it.opcode)
            lpht_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    slot_taken[i] = 1'b0;
                end
                push_result(1'b0, '0, '0, lpht_pkg::ST_OK, 1'b1);
            end
            lpht_pkg::OP_INSERT:
            begin
                if (it.key == lpht_pkg::EMPTY_MARK)
                begin
                    push_result(1'b0, it.row_number, '0, lpht_pkg::ST_IGNORED, 1'b1);
                end
                else
                begin
                    for (step = 0; step < n && !placed; step++)
                    begin
                        if (!slot_taken[idx])
                        begin
                            slot_taken[idx] = 1'b1;
                            stored_key[idx] = it.key;
                            stored_row[idx] = it.row_number;
                            placed = 1'b1;
                        end
                        else
                        begin
                            idx = (idx + 1) & (n - 1);
                        end
                    end
                    push_result(1'b0, it.row_number, '0,
                                placed ? lpht_pkg::ST_OK : lpht_pkg::ST_FULL, 1'b1);
                end
            end
            lpht_pkg::OP_PROBE:
            begin
                for (step = 0; step < n && slot_taken[idx] && !overflowed; step++)
                begin
                    if (stored_key[idx] == it.key)
                    begin
                        if (hit_total >= MAX_MATCHES)
                        begin
                            r = expected_results[expected_results.size() - 1];
                            r.status = lpht_pkg::ST_OVERFLOW;
                            expected_results[expected_results.size() - 1] = r;
                            overflowed = 1'b1;
                        end
                        else
                        begin
                            push_result(1'b1, stored_row[idx], it.row_number,
                                        lpht_pkg::ST_OK, 1'b0);
                            hit_total++;
                        end
                    end
                    idx = (idx + 1) & (n - 1);
                end
                if (hit_total == 0)
                begin
                    push_result(1'b0, '0, it.row_number, lpht_pkg::ST_OK, 1'b1);
                end
                else
                begin
                    r = expected_results[expected_results.size() - 1];
                    r.last = 1'b1;
                    expected_results[expected_results.size() - 1] = r;
                end
            end
            default:
            begin
                push_result(1'b0, '0, '0, lpht_pkg::ST_IGNORED, 1'b1);
            end
        endcase
    endtask

    task automatic check_result(input lpht_pkg::result_t got);
        lpht_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result beat with no item outstanding");
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                mismatches++;
            end
            if (got.build_row !== want.build_row)
            begin
                $error("build_row: expected %0h, got %0h", want.build_row, got.build_row);
                mismatches++;
            end
            if (got.probe_row !== want.probe_row)
            begin
                $error("probe_row: expected %0h, got %0h", want.probe_row, got.probe_row);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    // Result beats are checked before the item accepted at the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_taken[i] = 1'b0;
            end
            capacity = lpht_pkg::CAP_RESET;
            expected_results.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                check_result(result);
            end
            if (cfg_valid && cfg_ready)
            begin
                capacity = cfg_data;
            end
            if (start && !busy)
            begin
                predict_results(item);
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> bench/tb_top.sv
module tb_top;

    localparam int IDLE_LIMIT     = 10000;
    localparam int MAX_MATCHES_TB = lpht_pkg::DEFAULT_MAX_MATCHES;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    lpht_pkg::item_t            item;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [lpht_pkg::CAP_W-1:0] cfg_data;
    logic                       result_strobe;
    lpht_pkg::result_t          result;
    int                         mismatches;
    int                         pending;
    int                         idle_cycles;
    bit                         burst;

    linear_probe_hash_join_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_strobe(result_strobe),
        .result       (result)
    );

    join_table_scoreboard scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_strobe(result_strobe),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("linear_probe_hash_join_table regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input lpht_pkg::op_t op, input logic [lpht_pkg::KEY_W-1:0] key,
                             input logic [lpht_pkg::ROW_W-1:0] row);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{opcode: op, key: key, row_number: row};
        do
            @(posedge clk);
        while (busy);
    endtask

    // The sender holds off until every outstanding result beat has been seen.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic set_capacity(input logic [lpht_pkg::CAP_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        logic [lpht_pkg::KEY_W-1:0] pool [6];
        int pick;
        int k;
        for (k = 0; k < 6; k++)
        begin
            pool[k] = $urandom;
        end
        burst = ($urandom_range(0, 3) == 0);
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(lpht_pkg::OP_INSERT, pool[3'($urandom_range(0, 5))], $urandom);
            else if (pick < 82)
                send_item(lpht_pkg::OP_PROBE, pool[3'($urandom_range(0, 5))], $urandom);
            else if (pick < 86)
                send_item(lpht_pkg::OP_PROBE, $urandom, $urandom);
            else if (pick < 90)
                send_item(lpht_pkg::OP_INSERT, $urandom, $urandom);
            else if (pick < 93)
                send_item(lpht_pkg::OP_INSERT, lpht_pkg::EMPTY_MARK, $urandom);
            else if (pick < 97)
                send_item(lpht_pkg::OP_NOP, $urandom, $urandom);
            else
                send_item(lpht_pkg::OP_CLEAR, $urandom, $urandom);
        end
        burst = 1'b0;
    endtask

    initial
    begin
        logic [lpht_pkg::KEY_W-1:0] dup_key;
        int k;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        burst     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_capacity(4'd10);
        send_item(lpht_pkg::OP_CLEAR, '0, '0);
        send_item(lpht_pkg::OP_PROBE, '0, '0);
        send_item(lpht_pkg::OP_INSERT, lpht_pkg::EMPTY_MARK, 32'hFFFF_FFFF);
        send_item(lpht_pkg::OP_PROBE, lpht_pkg::EMPTY_MARK, 32'h0000_0001);
        send_item(lpht_pkg::OP_NOP, $urandom, $urandom);
        send_item(lpht_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(lpht_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_item(lpht_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
        send_item(lpht_pkg::OP_PROBE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(lpht_pkg::OP_PROBE, 32'h0000_0000, 32'h0000_0000);
        send_item(lpht_pkg::OP_PROBE, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_item(lpht_pkg::OP_PROBE, 32'h8000_0001, 32'h8000_0000);
        send_item(lpht_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lpht_pkg::OP_PROBE, 32'h7FFF_FFFF, 32'h0000_0002);

        // Smallest table: fill it with one key, overfill it and walk it end to end.
        set_capacity(4'd0);
        dup_key = $urandom;
        for (k = 0; k < 17; k++)
        begin
            send_item(lpht_pkg::OP_INSERT, dup_key, $urandom);
        end
        send_item(lpht_pkg::OP_INSERT, lpht_pkg::EMPTY_MARK, $urandom);
        send_item(lpht_pkg::OP_PROBE, dup_key, $urandom);
        send_item(lpht_pkg::OP_PROBE, ~dup_key, $urandom);

        // The stored entries stay while the mask widens.
        set_capacity(4'd15);
        send_item(lpht_pkg::OP_PROBE, dup_key, $urandom);
        send_item(lpht_pkg::OP_INSERT, dup_key, $urandom);
        send_item(lpht_pkg::OP_PROBE, dup_key, $urandom);

        set_capacity(4'd7);
        send_item(lpht_pkg::OP_CLEAR, $urandom, $urandom);
        dup_key = $urandom;
        burst = 1'b1;
        for (k = 0; k < MAX_MATCHES_TB + 1; k++)
        begin
            send_item(lpht_pkg::OP_INSERT, dup_key, $urandom);
        end
        burst = 1'b0;
        send_item(lpht_pkg::OP_PROBE, dup_key, $urandom);

        for (k = 0; k < 6; k++)
        begin
            set_capacity(4'($urandom_range(0, 15)));
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(lpht_pkg::OP_CLEAR, $urandom, $urandom);
            end
            random_phase(16);
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("linear_probe_hash_join_table regression: pass");
        end
        else
        begin
            $display("linear_probe_hash_join_table regression: fail");
        end
        $finish;
    end

endmodule
